/* design/rvfd_pkg.sv */
// Shared constants and types for the run-length video frame decoder.
// Used by rvfd_parser, rvfd_span and rle_video_frame_decoder_unit; no dependencies.
package rvfd_pkg;

  // Screen geometry of the external indexed frame memory.
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;

  // Widths of the stream payloads.
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // Span request from the parser: position is taken before the column advances.
  typedef struct packed {
    logic        result;   // this item produces a result item
    logic        write;    // a span was requested
    logic [7:0]  len;      // requested span length, 1..128
    logic [7:0]  color;
    logic [15:0] row;
    logic [15:0] col;
    logic        done;     // this item completes the frame body
  } span_req_t;

  // Clipped span ready for the output register.
  typedef struct packed {
    logic        result;
    logic [15:0] pixel_address;
    logic [7:0]  span_length;
    logic [7:0]  pixel_color;
    logic        clipped;
    logic        frame_done;
  } span_res_t;

endpackage

/* design/rle_video_frame_decoder_unit.sv */
// Top level of the run-length video frame decoder: stream ports and output register.
// Depends on rvfd_pkg, rvfd_parser and rvfd_span.
//
//  Channel | Direction | Payload
//  s_*     | in        | tdata: data_byte[7:0]; tuser: frame_start, is_delta
//  m_*     | out       | tdata: pixel_address, span_length, pixel_color; tuser: clipped;
//          |           | tlast: frame_done
//
// One compressed byte is taken per clock; each item is parsed in the cycle it
// is accepted and its result, if any, is loaded into the output register as
// that cycle ends. The input is stalled only while that register holds an
// untaken result. Reset (rst, synchronous) returns the parser to idle,
// waiting for a frame start, and empties the output register.
module rle_video_frame_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rvfd_pkg::IN_DATA_W-1:0]    s_tdata,   // data_byte[7:0]
  input  logic [rvfd_pkg::IN_USER_W-1:0]    s_tuser,   // frame_start[0], is_delta[1]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rvfd_pkg::OUT_DATA_W-1:0]   m_tdata,   // pixel_address[15:0],
                                                       // span_length[23:16],
                                                       // pixel_color[31:24]
  output logic [rvfd_pkg::OUT_USER_W-1:0]   m_tuser,   // clipped[0]
  output logic                              m_tlast    // frame_done
);

  logic                accept;
  rvfd_pkg::span_req_t req;
  rvfd_pkg::span_res_t res;

  // Input is taken whenever the output register is free or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  rvfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .frame_start (s_tuser[0]),
    .is_delta    (s_tuser[1]),
    .req         (req)
  );

  rvfd_span u_span (
    .req (req),
    .res (res)
  );

  // Output register: valid is control, payload loads with each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res.result;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata    <= {res.pixel_color, res.span_length, res.pixel_address};
      m_tuser[0] <= res.clipped;
      m_tlast    <= res.frame_done;
    end
  end

endmodule

/* design/rvfd_parser.sv */
// Frame body parser: holds the decode state and advances it by one item per accept.
// Depends on rvfd_pkg for screen constants and the span request type.
module rvfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  input  logic                is_delta,
  output rvfd_pkg::span_req_t req
);

  // Parse phases.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SKIP_LO = 4'd1;
  localparam logic [3:0] PH_SKIP_HI = 4'd2;
  localparam logic [3:0] PH_CNT_LO  = 4'd3;
  localparam logic [3:0] PH_CNT_HI  = 4'd4;
  localparam logic [3:0] PH_LINE    = 4'd5;
  localparam logic [3:0] PH_COLSKIP = 4'd6;
  localparam logic [3:0] PH_FLAG    = 4'd7;
  localparam logic [3:0] PH_LITERAL = 4'd8;
  localparam logic [3:0] PH_FILL    = 4'd9;

  logic [3:0]  parse_phase, parse_phase_next;
  logic        delta_mode, delta_mode_next;
  logic [15:0] row_index, row_index_next;
  logic [15:0] rows_remaining, rows_remaining_next;
  logic [15:0] column_index, column_index_next;
  logic [6:0]  segments_remaining, segments_remaining_next;
  logic [7:0]  literal_remaining, literal_remaining_next;
  logic [7:0]  run_length_held, run_length_held_next;
  logic [7:0]  header_low_byte, header_low_byte_next;

  // Next-state logic for one item, with the frame-start override applied first.
  always_comb begin
    logic        seg_end;
    logic        line_end;
    logic [15:0] hdr_word;
    logic [16:0] col_sum;
    logic [16:0] row_sum;

    parse_phase_next        = parse_phase;
    delta_mode_next         = delta_mode;
    row_index_next          = row_index;
    rows_remaining_next     = rows_remaining;
    column_index_next       = column_index;
    segments_remaining_next = segments_remaining;
    literal_remaining_next  = literal_remaining;
    run_length_held_next    = run_length_held;
    header_low_byte_next    = header_low_byte;
    seg_end                 = 1'b0;
    line_end                = 1'b0;
    hdr_word                = {data_byte, header_low_byte};
    col_sum                 = 17'd0;
    row_sum                 = 17'd0;

    req        = '0;
    req.color  = data_byte;

    if (frame_start) begin
      delta_mode_next         = is_delta;
      row_index_next          = '0;
      column_index_next       = '0;
      segments_remaining_next = '0;
      literal_remaining_next  = '0;
      run_length_held_next    = '0;
      if (is_delta) begin
        rows_remaining_next = '0;
        parse_phase_next    = PH_SKIP_LO;
      end else begin
        rows_remaining_next = 16'(rvfd_pkg::SCREEN_HEIGHT);
        parse_phase_next    = PH_LINE;
      end
    end

    hdr_word = {data_byte, header_low_byte_next};

    unique case (parse_phase_next)
      PH_SKIP_LO: begin
        header_low_byte_next = data_byte;
        parse_phase_next     = PH_SKIP_HI;
      end
      PH_SKIP_HI: begin
        row_index_next   = hdr_word;
        parse_phase_next = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        header_low_byte_next = data_byte;
        parse_phase_next     = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        if (data_byte[7] || hdr_word == 16'd0) begin
          rows_remaining_next = '0;
          parse_phase_next    = PH_IDLE;
          req.done            = 1'b1;
        end else begin
          rows_remaining_next = hdr_word;
          column_index_next   = '0;
          parse_phase_next    = PH_LINE;
        end
      end
      PH_LINE: begin
        column_index_next = '0;
        if (data_byte == 8'd0 || data_byte[7]) begin
          line_end = 1'b1;
        end else begin
          segments_remaining_next = data_byte[6:0];
          parse_phase_next        = delta_mode_next ? PH_COLSKIP : PH_FLAG;
        end
      end
      PH_COLSKIP: begin
        col_sum           = {1'b0, column_index_next} + {9'd0, data_byte};
        column_index_next = col_sum[16] ? 16'hFFFF : col_sum[15:0];
        parse_phase_next  = PH_FLAG;
      end
      PH_FLAG: begin
        if (!delta_mode_next) begin
          if (data_byte[7]) begin
            literal_remaining_next = 8'(9'd256 - {1'b0, data_byte});
            parse_phase_next       = PH_LITERAL;
          end else begin
            run_length_held_next = data_byte;
            parse_phase_next     = PH_FILL;
          end
        end else begin
          if (data_byte != 8'd0 && !data_byte[7]) begin
            literal_remaining_next = data_byte;
            parse_phase_next       = PH_LITERAL;
          end else begin
            run_length_held_next = (data_byte == 8'd0) ? 8'd0
                                   : 8'(9'd256 - {1'b0, data_byte});
            parse_phase_next     = PH_FILL;
          end
        end
      end
      PH_LITERAL: begin
        req.write = 1'b1;
        req.len   = 8'd1;
        if (literal_remaining_next != 8'd0) begin
          literal_remaining_next = literal_remaining_next - 8'd1;
        end
        if (literal_remaining_next == 8'd0) begin
          seg_end = 1'b1;
        end
      end
      PH_FILL: begin
        if (run_length_held_next != 8'd0) begin
          req.write = 1'b1;
          req.len   = run_length_held_next;
        end
        run_length_held_next = '0;
        seg_end              = 1'b1;
      end
      default: begin
        parse_phase_next = PH_IDLE;
      end
    endcase

    // A span is placed at the current position, then the column moves past it.
    req.row = row_index_next;
    req.col = column_index_next;
    if (req.write) begin
      col_sum           = {1'b0, column_index_next} + {9'd0, req.len};
      column_index_next = col_sum[16] ? 16'hFFFF : col_sum[15:0];
    end

    // End of a segment may close the line.
    if (seg_end) begin
      if (segments_remaining_next != 7'd0) begin
        segments_remaining_next = segments_remaining_next - 7'd1;
      end
      if (segments_remaining_next == 7'd0) begin
        line_end = 1'b1;
      end else begin
        parse_phase_next = delta_mode_next ? PH_COLSKIP : PH_FLAG;
      end
    end

    // End of a line may close the frame.
    if (line_end) begin
      row_sum           = {1'b0, row_index_next} + 17'd1;
      row_index_next    = row_sum[16] ? 16'hFFFF : row_sum[15:0];
      column_index_next = '0;
      if (rows_remaining_next != 16'd0) begin
        rows_remaining_next = rows_remaining_next - 16'd1;
      end
      if (rows_remaining_next == 16'd0) begin
        parse_phase_next = PH_IDLE;
        req.done         = 1'b1;
      end else begin
        parse_phase_next = PH_LINE;
      end
    end

    req.result = req.write | req.done;
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_IDLE;
      delta_mode         <= 1'b0;
      row_index          <= '0;
      rows_remaining     <= '0;
      column_index       <= '0;
      segments_remaining <= '0;
      literal_remaining  <= '0;
      run_length_held    <= '0;
      header_low_byte    <= '0;
    end else if (accept) begin
      parse_phase        <= parse_phase_next;
      delta_mode         <= delta_mode_next;
      row_index          <= row_index_next;
      rows_remaining     <= rows_remaining_next;
      column_index       <= column_index_next;
      segments_remaining <= segments_remaining_next;
      literal_remaining  <= literal_remaining_next;
      run_length_held    <= run_length_held_next;
      header_low_byte    <= header_low_byte_next;
    end
  end

endmodule

/* design/rvfd_span.sv */
// Span clipper: cuts a requested span to the screen and forms the pixel address.
// Depends on rvfd_pkg for screen constants and the request and result types.
module rvfd_span (
  input  rvfd_pkg::span_req_t req,
  output rvfd_pkg::span_res_t res
);

  logic        on_screen;
  logic [15:0] room;
  logic [15:0] req_len;
  logic [15:0] vis;
  logic [31:0] addr_full;

  // Visible part of the span: up to the right edge of the current line.
  assign on_screen = (32'(req.row) < 32'(rvfd_pkg::SCREEN_HEIGHT)) &&
                     (32'(req.col) < 32'(rvfd_pkg::SCREEN_WIDTH));
  assign room      = 16'(rvfd_pkg::SCREEN_WIDTH) - req.col;
  assign req_len   = {8'd0, req.len};
  assign vis       = !on_screen ? 16'd0 : ((req_len < room) ? req_len : room);

  // Row times width plus column; the multiplier is a constant.
  assign addr_full = 32'(req.row) * 32'(rvfd_pkg::SCREEN_WIDTH) + 32'(req.col);

  // Result fields; an empty span carries zero address and color.
  always_comb begin
    res               = '0;
    res.result        = req.result;
    res.frame_done    = req.done;
    if (req.write) begin
      res.clipped = (vis < req_len);
      if (vis != 16'd0) begin
        res.pixel_address = addr_full[15:0];
        res.span_length   = vis[7:0];
        res.pixel_color   = req.color;
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rle_video_frame_decoder_unit: sends key, delta and broken frame
// bodies with random gaps and output stalls, and checks every span against a local predictor.
// Depends on rvfd_pkg and the decoder RTL.
module tb;
  import rvfd_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    P_IDLE, P_SKIP_LO, P_SKIP_HI, P_CNT_LO, P_CNT_HI,
    P_LINE, P_COLSKIP, P_FLAG, P_LITERAL, P_FILL
  } parse_e;

  // One span write as seen on the output stream.
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  color;
    logic        clipped;
    logic        done;
  } span_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  // Decoder state as the predictor tracks it.
  parse_e      phase;
  logic        delta_frame;
  logic [15:0] row, rows_left, col;
  logic [7:0]  segs_left, lit_left, fill_len, hdr_lo;
  logic        frame_end;

  span_t span_q[$];
  int    errors;
  int    frame_items;
  int    idle_cycles;
  bit    send_calm;
  bit    recv_calm;
  bit    body_first;
  bit    body_delta;

  rle_video_frame_decoder_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [8:0] b);
    logic [16:0] s;
    s = a + b;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // A finished line moves down one row; the frame ends when no rows are left.
  function automatic void close_line();
    row = sat_add(row, 9'd1);
    col = '0;
    if (rows_left != 0) rows_left = rows_left - 16'd1;
    if (rows_left == 0) begin
      phase = P_IDLE;
      frame_end = 1'b1;
    end else begin
      phase = P_LINE;
    end
  endfunction

  function automatic void close_segment();
    if (segs_left != 0) segs_left = segs_left - 8'd1;
    if (segs_left == 0) close_line();
    else phase = delta_frame ? P_COLSKIP : P_FLAG;
  endfunction

  // Clip a span to the screen at the current position, then advance the column.
  function automatic span_t paint(input logic [8:0] len, input logic [7:0] color);
    span_t       sp;
    int unsigned r, c, vis, room, addr;
    r = row;
    c = col;
    vis = 0;
    if (r < SCREEN_HEIGHT && c < SCREEN_WIDTH) begin
      room = SCREEN_WIDTH - c;
      vis = (len < room) ? len : room;
    end
    addr = r * SCREEN_WIDTH + c;
    sp.addr = (vis != 0) ? addr[15:0] : 16'h0;
    sp.len = vis[7:0];
    sp.color = (vis != 0) ? color : 8'h0;
    sp.clipped = (vis < len);
    sp.done = 1'b0;
    col = sat_add(col, len);
    return sp;
  endfunction

  // Parse one compressed byte; returns 1 when it yields an output item.
  function automatic bit decode_byte(input logic [7:0] b, input logic start, input logic kind,
                                     output span_t sp);
    bit          wrote;
    logic [15:0] h;
    wrote = 1'b0;
    frame_end = 1'b0;
    sp = '0;
    if (start) begin
      delta_frame = kind;
      row = '0;
      col = '0;
      segs_left = '0;
      lit_left = '0;
      fill_len = '0;
      rows_left = kind ? 16'd0 : 16'(SCREEN_HEIGHT);
      phase = kind ? P_SKIP_LO : P_LINE;
    end
    case (phase)
      P_SKIP_LO: begin
        hdr_lo = b;
        phase = P_SKIP_HI;
      end
      P_SKIP_HI: begin
        row = {b, hdr_lo};
        phase = P_CNT_LO;
      end
      P_CNT_LO: begin
        hdr_lo = b;
        phase = P_CNT_HI;
      end
      P_CNT_HI: begin
        h = {b, hdr_lo};
        // A line count of zero or below ends the frame right here.
        if (b[7] || h == 0) begin
          rows_left = '0;
          phase = P_IDLE;
          frame_end = 1'b1;
        end else begin
          rows_left = h;
          col = '0;
          phase = P_LINE;
        end
      end
      P_LINE: begin
        col = '0;
        if (b == 0 || b[7]) begin
          close_line();
        end else begin
          segs_left = b;
          phase = delta_frame ? P_COLSKIP : P_FLAG;
        end
      end
      P_COLSKIP: begin
        col = sat_add(col, {1'b0, b});
        phase = P_FLAG;
      end
      P_FLAG: begin
        // Key frames: negative is literals. Delta frames: positive is literals.
        // Negating in 8 bits turns a count of minus 128 into 128.
        if (!delta_frame) begin
          if (b[7]) begin
            lit_left = 8'd0 - b;
            phase = P_LITERAL;
          end else begin
            fill_len = b;
            phase = P_FILL;
          end
        end else if (b != 0 && !b[7]) begin
          lit_left = b;
          phase = P_LITERAL;
        end else begin
          fill_len = 8'd0 - b;
          phase = P_FILL;
        end
      end
      P_LITERAL: begin
        sp = paint(9'd1, b);
        wrote = 1'b1;
        if (lit_left != 0) lit_left = lit_left - 8'd1;
        if (lit_left == 0) close_segment();
      end
      P_FILL: begin
        // A fill of length zero eats its color byte and writes nothing.
        if (fill_len != 0) begin
          sp = paint({1'b0, fill_len}, b);
          wrote = 1'b1;
        end
        fill_len = '0;
        close_segment();
      end
      default: phase = P_IDLE;
    endcase
    sp.done = frame_end;
    return wrote || frame_end;
  endfunction

  // Predict the output of every accepted input item.
  always @(posedge clk) begin : predict
    span_t sp;
    if (rst) begin
      phase = P_IDLE;
      delta_frame = 1'b0;
      row = '0;
      rows_left = '0;
      col = '0;
      segs_left = '0;
      lit_left = '0;
      fill_len = '0;
      hdr_lo = '0;
      frame_end = 1'b0;
    end else if (s_tvalid && s_tready) begin
      if (s_tuser[0] || phase != P_IDLE) frame_items++;
      if (decode_byte(s_tdata, s_tuser[0], s_tuser[1], sp)) span_q.push_back(sp);
    end
  end

  // Compare each output item with the oldest predicted span.
  always @(posedge clk) begin : check
    span_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[23:16], m_tdata[31:24], m_tuser[0], m_tlast};
      if (span_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected span: addr %0d len %0d color %0d clipped %0b done %0b",
                   got.addr, got.len, got.color, got.clipped, got.done);
      end else begin
        want = span_q.pop_front();
        if (got.addr !== want.addr || got.len !== want.len || got.color !== want.color ||
            got.clipped !== want.clipped || got.done !== want.done) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("span mismatch: expected addr %0d len %0d color %0d clipped %0b done %0b",
                     want.addr, want.len, want.color, want.clipped, want.done,
                     "; got addr %0d len %0d color %0d clipped %0b done %0b",
                     got.addr, got.len, got.color, got.clipped, got.done);
        end
      end
    end
  end

  // Stop a hung run: too many cycles without any item moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stall before each item, with calm stretches now and then.
  initial begin : receive
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic start, input logic kind);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= {kind, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic begin_frame(input logic kind);
    body_first = 1'b1;
    body_delta = kind;
  endtask

  // Frame body byte; the kind bit only matters on the first one, so it is random after that.
  task automatic send_body(input logic [7:0] b);
    send_item(b, body_first, body_first ? body_delta : 1'($urandom_range(0, 1)));
    body_first = 1'b0;
  endtask

  task automatic send_segment(input logic delta);
    int         n;
    logic [7:0] flag;
    if (delta)
      send_body(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(0, 40)));
    if ($urandom_range(0, 1) == 0) begin
      // Literal run: mostly short, sometimes long.
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(5, delta ? 127 : 128)
                                       : $urandom_range(1, 4);
      flag = delta ? 8'(n) : 8'(256 - n);
      send_body(flag);
      repeat (n) send_body(8'($urandom));
    end else begin
      n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, delta ? 128 : 127);
      flag = delta ? ((n == 0) ? 8'h00 : 8'(256 - n)) : 8'(n);
      send_body(flag);
      send_body(8'($urandom));
    end
  endtask

  task automatic send_line(input logic delta);
    int segs;
    case ($urandom_range(0, 7))
      0: send_body(8'($urandom_range(128, 255)));
      1: send_body(8'h00);
      default: begin
        segs = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        send_body(8'(segs));
        repeat (segs) send_segment(delta);
      end
    endcase
  endtask

  task automatic send_key_frame(input int busy);
    int i;
    begin_frame(1'b0);
    for (i = 0; i < SCREEN_HEIGHT; i++) begin
      if ($urandom_range(0, SCREEN_HEIGHT - 1) < busy) send_line(1'b0);
      else send_body(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(128, 255)));
    end
  endtask

  task automatic send_delta_frame();
    int skip, lines;
    case ($urandom_range(0, 9))
      0: skip = $urandom_range(SCREEN_HEIGHT - 3, SCREEN_HEIGHT + 2);
      1: skip = $urandom_range(256, 65535);
      default: skip = $urandom_range(0, SCREEN_HEIGHT - 1);
    endcase
    lines = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
    begin_frame(1'b1);
    send_body(8'(skip));
    send_body(8'(skip >> 8));
    if (lines == 0 && $urandom_range(0, 1) == 1) begin
      send_body(8'($urandom));
      send_body(8'($urandom_range(128, 255)));
    end else begin
      send_body(8'(lines));
      send_body(8'h00);
    end
    repeat (lines) send_line(1'b1);
  endtask

  // A frame start followed by raw bytes; usually cut short by the next frame start.
  task automatic send_broken_frame();
    begin_frame(1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 12)) send_body(8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10))
      send_item(8'($urandom), ($urandom_range(0, 15) == 0), 1'($urandom_range(0, 1)));
  endtask

  // Bytes outside a frame must be dropped without output.
  task automatic test_idle_bytes();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
  endtask

  // Delta frame with a minus-128 fill, column skips, literals and a zero-length fill.
  task automatic test_delta_spans();
    begin_frame(1'b1);
    send_body(8'h03); send_body(8'h00); send_body(8'h01); send_body(8'h00);
    send_body(8'h03);
    send_body(8'h00); send_body(8'h80); send_body(8'hFF);
    send_body(8'h05); send_body(8'h02); send_body(8'h11); send_body(8'h22);
    send_body(8'h00); send_body(8'h00); send_body(8'h77);
  endtask

  // Delta line counts of zero and below complete the frame on the header.
  task automatic test_empty_delta();
    begin_frame(1'b1);
    send_body(8'h00); send_body(8'h00); send_body(8'h00); send_body(8'h00);
    begin_frame(1'b1);
    send_body(8'h34); send_body(8'h12); send_body(8'hFF); send_body(8'h80);
  endtask

  // Spans past the right edge and below the bottom row.
  task automatic test_offscreen();
    begin_frame(1'b1);
    send_body(8'hC7); send_body(8'h00); send_body(8'h02); send_body(8'h00);
    send_body(8'h01); send_body(8'hFF); send_body(8'h80); send_body(8'h5A);
    send_body(8'h01); send_body(8'h00); send_body(8'h01); send_body(8'h3C);
  endtask

  // A line skip of 65535 makes the row counter saturate at the line end.
  task automatic test_row_saturation();
    begin_frame(1'b1);
    send_body(8'hFF); send_body(8'hFF); send_body(8'h02); send_body(8'h00);
    send_body(8'h00); send_body(8'h80);
  endtask

  // A frame start in the middle of a literal run abandons the old frame.
  task automatic test_restart();
    begin_frame(1'b1);
    send_body(8'h00); send_body(8'h00); send_body(8'h02); send_body(8'h00);
    send_body(8'h01); send_body(8'h00); send_body(8'h03); send_body(8'hAA);
    begin_frame(1'b1);
    send_body(8'h0A); send_body(8'h00); send_body(8'h01); send_body(8'h00);
    send_body(8'h01); send_body(8'h00); send_body(8'hFE); send_body(8'h44);
  endtask

  task automatic test_key_frame();
    int i;
    send_calm = 1'b1;
    begin_frame(1'b0);
    // Line 0: a long fill, one literal and a fill of length zero.
    send_body(8'h03);
    send_body(8'h7F); send_body(8'h01);
    send_body(8'hFF); send_body(8'h00);
    send_body(8'h00); send_body(8'h55);
    // Line 1: three long fills; the last one runs off the right edge.
    send_body(8'h03);
    for (i = 0; i < 3; i++) begin
      send_body(8'h7F);
      send_body(8'(8'hAB + i));
    end
    // Line 2: a literal count of minus 128 means 128 literal bytes.
    send_body(8'h01);
    send_body(8'h80);
    repeat (128) send_body(8'($urandom));
    // Line 3: a negative segment count leaves the line empty.
    send_body(8'h80);
    for (i = 4; i < SCREEN_HEIGHT - 1; i++) send_body(8'h00);
    // Bottom line: one pixel that also completes the frame.
    send_body(8'h01); send_body(8'hFF); send_body(8'h99);
    send_calm = 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with broken frames and noise.
  task automatic test_random_traffic();
    while (frame_items < ITEM_TARGET) begin
      send_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0: send_key_frame($urandom_range(0, 12));
        1, 2: send_broken_frame();
        3, 4: send_noise();
        default: send_delta_frame();
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_delta_spans();
    test_empty_delta();
    test_offscreen();
    test_row_saturation();
    test_restart();
    test_key_frame();
    test_random_traffic();
    s_tvalid <= 1'b0;
    // Drain, then allow for the output register.
    while (span_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && span_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
